[sv/lidar_packet_bin_decoder_defines.svh]
`ifndef LIDAR_PACKET_BIN_DECODER_DEFINES_SVH
`define LIDAR_PACKET_BIN_DECODER_DEFINES_SVH

// condition holds at every edge out of reset
`define LPBD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LPBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[sv/lpbd_pkg.sv]
package lpbd_pkg;

  localparam int BIN_COUNT    = 1024;
  localparam int HEADER_BYTES = 10;

  localparam int DIV_W     = 32;
  localparam int DVS_W     = 20;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [9:0] BIN_MAX = 10'(BIN_COUNT - 1);

  localparam logic [9:0] POS_TYPE     = 10'd2;
  localparam logic [9:0] POS_COUNT    = 10'd3;
  localparam logic [9:0] POS_FIRST_LO = 10'd4;
  localparam logic [9:0] POS_FIRST_HI = 10'd5;
  localparam logic [9:0] POS_LAST_LO  = 10'd6;
  localparam logic [9:0] POS_LAST_HI  = 10'd7;
  localparam logic [9:0] POS_DATA     = 10'(HEADER_BYTES);
  localparam logic [9:0] POS_MAX      = 10'd1023;

  localparam logic [7:0] TYPE_START = 8'd1;
  localparam logic [7:0] MIN_COUNT  = 8'd10;

  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  localparam logic [1:0] REG_ANGLE_LOW  = 2'd0;
  localparam logic [1:0] REG_ANGLE_HIGH = 2'd1;
  localparam logic [1:0] REG_RANGE_LOW  = 2'd2;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd3;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_first;
  } packet_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  bin_number;
    logic [15:0] bin_distance;
    logic [15:0] scan_number;
  } result_t;

  function automatic logic [17:0] atan_step(input logic [3:0] i);
    logic [17:0] v;
    case (i)
      4'd0:    v = 18'd184320;
      4'd1:    v = 18'd108810;
      4'd2:    v = 18'd57492;
      4'd3:    v = 18'd29184;
      4'd4:    v = 18'd14649;
      4'd5:    v = 18'd7331;
      4'd6:    v = 18'd3667;
      4'd7:    v = 18'd1833;
      4'd8:    v = 18'd917;
      4'd9:    v = 18'd458;
      4'd10:   v = 18'd229;
      4'd11:   v = 18'd115;
      4'd12:   v = 18'd57;
      4'd13:   v = 18'd29;
      4'd14:   v = 18'd14;
      4'd15:   v = 18'd7;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/lpbd_div.sv]
module lpbd_div import lpbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= '0;
      dvs  <= '0;
      rem  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= DIV_CNT_W'(DIV_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        dvd <= {dvd[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[sv/lpbd_cordic.sv]
module lpbd_cordic import lpbd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        distance,
  output logic               busy,
  output logic signed [20:0] correction
);

  logic signed [47:0] x;
  logic signed [47:0] y;
  logic signed [20:0] z;
  logic [3:0]         step;
  logic               neg;
  logic               zero;

  logic signed [21:0] diff;
  logic signed [29:0] diff_w;
  logic signed [29:0] yv;
  logic [29:0]        ymag;
  logic [22:0]        xv;
  logic signed [47:0] xs;
  logic signed [47:0] ys;
  logic signed [20:0] ang;

  assign diff   = 22'sd6212 - $signed({6'd0, distance}) * 22'sd10;
  assign diff_w = {{8{diff[21]}}, diff};
  assign yv     = diff_w * 30'sd218;
  assign ymag   = yv[29] ? 30'(-yv) : 30'(yv);
  assign xv     = 23'(24'd62120 + 24'd100 * {8'd0, distance});
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign ang    = $signed({3'b000, atan_step(step)});

  assign correction = zero ? 21'sd0 : (neg ? -z : z);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      neg  <= 1'b0;
      zero <= 1'b1;
      x    <= '0;
      y    <= '0;
      z    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      neg  <= yv[29];
      zero <= distance == 16'd0;
      x    <= $signed({9'd0, xv, 16'd0});
      y    <= $signed({2'd0, ymag, 16'd0});
      z    <= '0;
    end else if (busy) begin
      if (!y[47]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end
      step <= step + 1'b1;
      if (step == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/lidar_packet_bin_decoder.sv]
// Lidar packet decoder: takes packet bytes one request at a time and gives a bin write for
// each sample of a usable packet, or a scan-complete result for a start packet. Header and
// low distance bytes are taken in the idle state; the type byte of a start packet then stalls
// through the emit state. The high byte of a usable sample stalls through two 32-step passes
// of the shared restoring divider (angle interpolation, then bin number) and the states
// MUL1, DIV1, FIX, MUL2, DIV2 and EMIT; the 16-step triangulation correction runs alongside
// the first pass. Both results also wait while an earlier result is held in the output
// register. The finished result sits in the output register while the next byte is taken.
`include "lidar_packet_bin_decoder_defines.svh"

module lidar_packet_bin_decoder import lpbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        packet_valid,
  output logic        packet_stall,
  input  packet_t     packet,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_FIX,
    ST_MUL2,
    ST_DIV2,
    ST_EMIT
  } state_t;

  state_t state;

  logic [14:0] angle_low_limit;
  logic [14:0] angle_high_limit;
  logic [15:0] range_low_limit;
  logic [15:0] range_high_limit;

  logic [9:0]  byte_position;
  logic [7:0]  sample_count;
  logic [15:0] first_angle;
  logic [15:0] last_angle;
  logic [15:0] angle_span;
  logic        packet_usable;
  logic [7:0]  low_distance_byte;
  logic [7:0]  sample_number;
  logic [15:0] scan_counter;

  logic [15:0]        sample_dist;
  logic [7:0]         sample_k;
  logic signed [23:0] ang;
  logic               filtered;
  result_t            pending;

  logic               accept;
  logic [9:0]         pos;
  logic [9:0]         data_off;
  logic [7:0]         b;
  logic [14:0]        last_next;
  logic signed [17:0] span;
  logic signed [25:0] span100;
  logic signed [25:0] lo_bound;
  logic signed [25:0] hi_bound;
  logic [DVS_W-1:0]   span64;
  logic [27:0]        prod1;
  logic [28:0]        prod2;
  logic signed [23:0] ang_sum;
  logic signed [23:0] mirrored;
  logic signed [23:0] wrapped;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic               cor_start;
  logic               cor_busy;
  logic signed [20:0] cor_value;

  assign packet_stall = state != ST_IDLE;
  assign accept       = packet_valid && !packet_stall;
  assign b            = packet.packet_byte;
  assign pos          = packet.packet_first ? 10'd0 : byte_position;
  assign data_off     = pos - POS_DATA;

  assign last_next = 15'({b, last_angle[7:0]} >> 1);
  assign span      = (first_angle > {1'b0, last_next})
                   ? 18'sd23040 - $signed({2'b0, first_angle}) + $signed({3'b0, last_next})
                   : $signed({3'b0, last_next}) - $signed({2'b0, first_angle});
  assign span100   = {{8{span[17]}}, span} * 26'sd100;
  assign lo_bound  = $signed({18'd0, sample_count}) * 26'sd3616;
  assign hi_bound  = $signed({18'd0, sample_count}) * 26'sd4256;

  assign span64 = {angle_span[13:0], 6'd0};
  assign prod1  = span64 * sample_k;
  assign prod2  = ang[20:0] * sample_count;

  assign ang_sum  = $signed({2'b0, first_angle, 6'd0}) + $signed({4'b0, div_quot[19:0]})
                  + {{3{cor_value[20]}}, cor_value};
  assign mirrored = 24'sd2949120 - ang;
  assign wrapped  = (mirrored > 24'sd1474560) ? mirrored - 24'sd1474560 : mirrored;

  assign cor_start    = state == ST_MUL1;
  assign div_start    = (state == ST_MUL1) || (state == ST_MUL2);
  assign div_dividend = (state == ST_MUL1) ? {4'd0, prod1}
                      : (ang[23] ? '0 : {3'd0, prod2});
  assign div_divisor  = (state == ST_MUL1) ? {12'd0, sample_count - 8'd1} : span64;

  lpbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  lpbd_cordic u_cordic (
    .clk        (clk),
    .rst        (rst),
    .start      (cor_start),
    .distance   (sample_dist),
    .busy       (cor_busy),
    .correction (cor_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      result_valid      <= 1'b0;
      result            <= '0;
      pending           <= '0;
      angle_low_limit   <= 15'd0;
      angle_high_limit  <= 15'd23040;
      range_low_limit   <= 16'd0;
      range_high_limit  <= 16'd65535;
      byte_position     <= '0;
      sample_count      <= '0;
      first_angle       <= '0;
      last_angle        <= '0;
      angle_span        <= '0;
      packet_usable     <= 1'b0;
      low_distance_byte <= '0;
      sample_number     <= '0;
      scan_counter      <= '0;
      sample_dist       <= '0;
      sample_k          <= '0;
      ang               <= '0;
      filtered          <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_ANGLE_LOW:  angle_low_limit  <= cfg_data[14:0];
          REG_ANGLE_HIGH: angle_high_limit <= cfg_data[14:0];
          REG_RANGE_LOW:  range_low_limit  <= cfg_data;
          REG_RANGE_HIGH: range_high_limit <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_position <= (pos < POS_MAX) ? pos + 10'd1 : pos;
            case (pos)
              POS_TYPE: begin
                sample_number <= '0;
                if (b == TYPE_START) begin
                  packet_usable        <= 1'b0;
                  pending.result_kind  <= KIND_SCAN;
                  pending.bin_number   <= '0;
                  pending.bin_distance <= '0;
                  pending.scan_number  <= scan_counter;
                  scan_counter         <= scan_counter + 16'd1;
                  state                <= ST_EMIT;
                end else begin
                  packet_usable <= 1'b1;
                end
              end
              POS_COUNT: begin
                sample_count <= b;
                if (b <= MIN_COUNT) begin
                  packet_usable <= 1'b0;
                end
              end
              POS_FIRST_LO: first_angle <= {8'd0, b};
              POS_FIRST_HI: first_angle <= 16'({b, first_angle[7:0]} >> 1);
              POS_LAST_LO:  last_angle  <= {8'd0, b};
              POS_LAST_HI: begin
                last_angle <= {1'b0, last_next};
                angle_span <= span[15:0];
                if (!(span100 >= lo_bound && span100 <= hi_bound)) begin
                  packet_usable <= 1'b0;
                end
              end
              default: begin
                if (pos >= POS_DATA) begin
                  if (!data_off[0]) begin
                    low_distance_byte <= b;
                  end else begin
                    if (packet_usable && sample_number < sample_count) begin
                      sample_dist <= {b, low_distance_byte};
                      sample_k    <= sample_number;
                      state       <= ST_MUL1;
                    end
                    if (sample_number < 8'd255) begin
                      sample_number <= sample_number + 8'd1;
                    end
                  end
                end
              end
            endcase
          end
        end
        ST_MUL1: state <= ST_DIV1;
        ST_DIV1: begin
          if (div_done) begin
            ang   <= ang_sum;
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          ang      <= wrapped;
          filtered <= (wrapped < $signed({3'b0, angle_low_limit, 6'd0}))
                   || (wrapped > $signed({3'b0, angle_high_limit, 6'd0}))
                   || (sample_dist < range_low_limit) || (sample_dist > range_high_limit);
          state    <= ST_MUL2;
        end
        ST_MUL2: state <= ST_DIV2;
        ST_DIV2: begin
          if (div_done) begin
            pending.result_kind  <= KIND_BIN;
            pending.bin_number   <= (div_quot > DIV_W'(BIN_MAX)) ? BIN_MAX : div_quot[9:0];
            pending.bin_distance <= filtered ? 16'd0 : sample_dist;
            pending.scan_number  <= '0;
            state                <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!result_valid || !result_stall) begin
            result       <= pending;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LPBD_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
  `LPBD_ASSERT_IMP(a_cor_first, (state == ST_DIV1) && div_done, !cor_busy, "correction late")
  `LPBD_ASSERT_IMP(a_usable_count, packet_usable && (byte_position > POS_COUNT),
                   sample_count > MIN_COUNT, "usable packet with too few samples")
  `LPBD_ASSERT_ALWAYS(a_scan_clean, !(result_valid && result.result_kind == KIND_SCAN)
                      || (result.bin_number == '0 && result.bin_distance == '0),
                      "scan result carries bin data")

endmodule
